>>> sv/i2cbm_pkg.sv
// Shared types and constants for the byte-level I2C master.
package i2cbm_pkg;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ST_RISE,
    PH_ST_HOLD1,
    PH_ST_HOLD2,
    PH_BIT_LOW,
    PH_BIT_RISE,
    PH_BIT_HIGH,
    PH_BIT_TAIL,
    PH_SP_RISE,
    PH_SP_HOLD1,
    PH_SP_HOLD2
  } phase_e;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_e;

  localparam int unsigned HalfW      = 16;
  localparam int unsigned InDataW    = 16;
  localparam int unsigned OutDataW   = 16;
  localparam logic [HalfW-1:0] HalfReset = 16'd10;
  localparam logic [7:0] ByteOnes    = 8'hFF;
  localparam logic [7:0] ByteZeros   = 8'h00;
  localparam logic [3:0] DataBits    = 4'd8;

endpackage

>>> sv/i2c_byte_master.sv
// The result item of each accepted item is registered in the output register.
// Throughput: one item per cycle; the only limit is the output register, which frees
// in the same cycle that its result item is taken.
// Reset: asynchronous, active low; back to idle with both lines released, the half
// period at 10 ticks, shift byte at all ones, held read byte and NACK cleared.
module i2c_byte_master (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [i2cbm_pkg::HalfW-1:0]   cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // command_valid[0], command[2:1], data_byte[10:3], send_ack[11], scl_in[12],
  // sda_in[13], zero fill[15:14]
  input  logic [i2cbm_pkg::InDataW-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // scl_low[0], sda_low[1], busy_res[2], done_res[3], read_byte[11:4], nack[12],
  // zero fill[15:13]
  output logic [i2cbm_pkg::OutDataW-1:0] m_axis_tdata
);
  import i2cbm_pkg::*;

  logic            in_valid, in_ack, in_scl, in_sda;
  cmd_e            in_cmd;
  logic [7:0]      in_byte;

  phase_e          phase_q, phase_d;
  cmd_e            cmd_q, cmd_d;
  logic [7:0]      shift_q, shift_d;
  logic [3:0]      bit_q, bit_d, bit_inc;
  logic [HalfW-1:0] wait_q, wait_d, half_q, half_eff;
  logic            ackc_q, ackc_d;
  logic            scl_q, scl_d, sda_q, sda_d;
  logic [7:0]      read_q, read_d;
  logic            nack_q, nack_d;
  logic            done_d, wait_done, wait_phase, arm;
  logic            out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic            in_fire;

  assign in_valid = s_axis_tdata[0];
  assign in_cmd   = cmd_e'(s_axis_tdata[2:1]);
  assign in_byte  = s_axis_tdata[10:3];
  assign in_ack   = s_axis_tdata[11];
  assign in_scl   = s_axis_tdata[12];
  assign in_sda   = s_axis_tdata[13];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign half_eff  = (half_q == '0) ? HalfW'(1) : half_q;
  assign wait_done = (wait_q <= HalfW'(1));
  assign bit_inc   = bit_q + 4'd1;

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_IDLE: begin
        if (in_valid) begin
          unique case (in_cmd)
            CMD_START: phase_d = PH_ST_RISE;
            CMD_STOP:  phase_d = PH_SP_RISE;
            default:   phase_d = PH_BIT_LOW;
          endcase
        end
      end
      PH_ST_RISE:  if (in_scl) phase_d = PH_ST_HOLD1;
      PH_ST_HOLD1: if (wait_done) phase_d = PH_ST_HOLD2;
      PH_ST_HOLD2: if (wait_done) phase_d = PH_BIT_LOW;
      PH_BIT_LOW:  if (wait_done) phase_d = PH_BIT_RISE;
      PH_BIT_RISE: if (in_scl) phase_d = PH_BIT_HIGH;
      PH_BIT_HIGH: begin
        if (wait_done) phase_d = (bit_inc >= DataBits) ? PH_BIT_TAIL : PH_BIT_LOW;
      end
      PH_BIT_TAIL: begin
        if (wait_done) phase_d = (bit_q == DataBits) ? PH_BIT_LOW : PH_IDLE;
      end
      PH_SP_RISE:  if (in_scl) phase_d = PH_SP_HOLD1;
      PH_SP_HOLD1: if (wait_done) phase_d = PH_SP_HOLD2;
      PH_SP_HOLD2: if (wait_done) phase_d = PH_IDLE;
      default:     phase_d = PH_IDLE;
    endcase
  end

  always_comb begin
    case (phase_d)
      PH_ST_HOLD1, PH_ST_HOLD2, PH_BIT_LOW, PH_BIT_HIGH, PH_BIT_TAIL,
      PH_SP_HOLD1, PH_SP_HOLD2: wait_phase = 1'b1;
      default:                  wait_phase = 1'b0;
    endcase
  end

  // Every entry into a timed phase loads a fresh half period.
  assign arm = (phase_d != phase_q) && wait_phase;

  // Datapath and pin drives.
  always_comb begin
    cmd_d   = cmd_q;
    shift_d = shift_q;
    bit_d   = bit_q;
    ackc_d  = ackc_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    read_d  = read_q;
    nack_d  = nack_q;
    done_d  = 1'b0;
    wait_d  = wait_q;

    case (phase_q)
      PH_ST_HOLD1, PH_ST_HOLD2, PH_BIT_LOW, PH_BIT_HIGH, PH_BIT_TAIL,
      PH_SP_HOLD1, PH_SP_HOLD2: wait_d = wait_done ? '0 : wait_q - HalfW'(1);
      default: ;
    endcase

    case (phase_q)
      PH_IDLE: begin
        if (in_valid) begin
          cmd_d  = in_cmd;
          ackc_d = in_ack;
          bit_d  = '0;
          case (in_cmd)
            CMD_START: begin
              shift_d = in_byte;
              scl_d   = 1'b0;
            end
            CMD_WRITE: shift_d = in_byte;
            CMD_READ:  shift_d = ByteOnes;
            default: begin
              sda_d = 1'b1;
              scl_d = 1'b0;
            end
          endcase
        end
      end
      PH_ST_HOLD1: if (wait_done) sda_d = 1'b1;
      PH_BIT_LOW:  if (wait_done) scl_d = 1'b0;
      PH_BIT_RISE: if (in_scl) shift_d = {shift_q[6:0], in_sda};
      PH_BIT_HIGH: begin
        if (wait_done) begin
          scl_d = 1'b1;
          bit_d = bit_inc;
        end
      end
      PH_BIT_TAIL: begin
        if (wait_done) begin
          if (bit_q == DataBits) begin
            if (cmd_q == CMD_READ) begin
              read_d  = shift_q;
              shift_d = ackc_q ? ByteZeros : ByteOnes;
            end else begin
              shift_d = ByteOnes;
            end
          end else begin
            if (cmd_q != CMD_READ) nack_d = shift_q[0];
            shift_d = ByteOnes;
            sda_d   = 1'b0;
            bit_d   = '0;
            done_d  = 1'b1;
          end
        end
      end
      PH_SP_HOLD1: if (wait_done) sda_d = 1'b0;
      PH_SP_HOLD2: if (wait_done) done_d = 1'b1;
      default: ;
    endcase

    if (arm) wait_d = half_eff;

    // Each bit starts with SCL low and SDA set from the top of the shift byte.
    if (phase_d == PH_BIT_LOW && phase_q != PH_BIT_LOW) begin
      scl_d = 1'b1;
      sda_d = !shift_d[7];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cmd_q   <= CMD_START;
      shift_q <= ByteOnes;
      bit_q   <= '0;
      wait_q  <= '0;
      ackc_q  <= 1'b0;
      scl_q   <= 1'b0;
      sda_q   <= 1'b0;
      read_q  <= ByteZeros;
      nack_q  <= 1'b0;
      half_q  <= HalfReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) half_q <= cfg_wdata_i;
      if (in_fire) begin
        phase_q <= phase_d;
        cmd_q   <= cmd_d;
        shift_q <= shift_d;
        bit_q   <= bit_d;
        wait_q  <= wait_d;
        ackc_q  <= ackc_d;
        scl_q   <= scl_d;
        sda_q   <= sda_d;
        read_q  <= read_d;
        nack_q  <= nack_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= {3'b000, nack_d, read_d, done_d, (phase_d != PH_IDLE), sda_d, scl_d};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_item_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted item produced no result");

  a_done_means_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && done_d |-> phase_d == PH_IDLE)
    else $error("done reported while the next phase is not idle");

  a_bit_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_q <= 4'd9)
    else $error("bit counter beyond the ACK bit");

  a_empty_takes_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with an empty output register");

  a_idle_no_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && phase_q != PH_IDLE && phase_d == PH_IDLE |=> wait_q == '0)
    else $error("wait counter left running on return to idle");

endmodule

>>> tb/i2c_byte_master_checker.sv
// Checker for the I2C byte master: predicts each result item and compares it.
module i2c_byte_master_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [i2cbm_pkg::HalfW-1:0]    cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [i2cbm_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [i2cbm_pkg::OutDataW-1:0] m_axis_tdata,
  output int                             fail_count,
  output int                             expected_left
);
  timeunit 1ns;
  timeprecision 1ps;
  import i2cbm_pkg::*;

  // Same bit order as the result tdata, scl_low in bit 0.
  typedef struct packed {
    logic       nack;
    logic [7:0] read_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_low;
    logic       scl_low;
  } bus_report_t;

  bus_report_t expected_reports[$];

  logic [HalfW-1:0] half_ticks;
  phase_e           phase_q;
  cmd_e             cmd_q;
  logic [7:0]       shift_q;
  logic [3:0]       bits_q;
  logic [15:0]      wait_q;
  logic             ack_choice_q;
  logic             scl_drive_q;
  logic             sda_drive_q;
  logic [7:0]       read_q;
  logic             nack_q;

  function automatic void reset_master();
    half_ticks   = HalfReset;
    phase_q      = PH_IDLE;
    cmd_q        = CMD_START;
    shift_q      = ByteOnes;
    bits_q       = '0;
    wait_q       = '0;
    ack_choice_q = 1'b0;
    scl_drive_q  = 1'b0;
    sda_drive_q  = 1'b0;
    read_q       = '0;
    nack_q       = 1'b0;
  endfunction

  function automatic void arm_wait();
    wait_q = (half_ticks == '0) ? 16'd1 : half_ticks;
  endfunction

  // Counts one tick of the running wait; true on its last tick.
  function automatic logic wait_elapsed();
    if (wait_q > 16'd1) begin
      wait_q = wait_q - 16'd1;
      return 1'b0;
    end
    wait_q = '0;
    return 1'b1;
  endfunction

  function automatic void start_bit_low();
    scl_drive_q = 1'b1;
    sda_drive_q = ~shift_q[7];
    phase_q     = PH_BIT_LOW;
    arm_wait();
  endfunction

  function automatic bus_report_t advance_tick(logic [InDataW-1:0] item);
    logic        offer;
    cmd_e        cmd;
    logic [7:0]  data;
    logic        ack_in;
    logic        scl_in;
    logic        sda_in;
    logic        done;
    bus_report_t rep;
    offer  = item[0];
    cmd    = cmd_e'(item[2:1]);
    data   = item[10:3];
    ack_in = item[11];
    scl_in = item[12];
    sda_in = item[13];
    done   = 1'b0;
    case (phase_q)
      PH_IDLE: begin
        if (offer) begin
          cmd_q        = cmd;
          ack_choice_q = ack_in;
          bits_q       = '0;
          case (cmd)
            CMD_START: begin
              shift_q     = data;
              scl_drive_q = 1'b0;
              phase_q     = PH_ST_RISE;
            end
            CMD_WRITE: begin
              shift_q = data;
              start_bit_low();
            end
            CMD_READ: begin
              shift_q = ByteOnes;
              start_bit_low();
            end
            default: begin
              sda_drive_q = 1'b1;
              scl_drive_q = 1'b0;
              phase_q     = PH_SP_RISE;
            end
          endcase
        end
      end
      PH_ST_RISE: begin
        if (scl_in) begin
          phase_q = PH_ST_HOLD1;
          arm_wait();
        end
      end
      PH_ST_HOLD1: begin
        if (wait_elapsed()) begin
          sda_drive_q = 1'b1;
          phase_q     = PH_ST_HOLD2;
          arm_wait();
        end
      end
      PH_ST_HOLD2: begin
        if (wait_elapsed()) start_bit_low();
      end
      PH_BIT_LOW: begin
        if (wait_elapsed()) begin
          scl_drive_q = 1'b0;
          phase_q     = PH_BIT_RISE;
        end
      end
      PH_BIT_RISE: begin
        if (scl_in) begin
          shift_q = {shift_q[6:0], sda_in};
          phase_q = PH_BIT_HIGH;
          arm_wait();
        end
      end
      PH_BIT_HIGH: begin
        if (wait_elapsed()) begin
          scl_drive_q = 1'b1;
          bits_q      = bits_q + 4'd1;
          if (bits_q >= DataBits) begin
            phase_q = PH_BIT_TAIL;
            arm_wait();
          end else begin
            start_bit_low();
          end
        end
      end
      PH_BIT_TAIL: begin
        if (wait_elapsed()) begin
          if (bits_q == DataBits) begin
            // Data byte done; the ninth bit is the acknowledge slot.
            if (cmd_q == CMD_READ) begin
              read_q  = shift_q;
              shift_q = ack_choice_q ? ByteZeros : ByteOnes;
            end else begin
              shift_q = ByteOnes;
            end
            start_bit_low();
          end else begin
            if (cmd_q != CMD_READ) nack_q = shift_q[0];
            shift_q     = ByteOnes;
            sda_drive_q = 1'b0;
            bits_q      = '0;
            phase_q     = PH_IDLE;
            done        = 1'b1;
          end
        end
      end
      PH_SP_RISE: begin
        if (scl_in) begin
          phase_q = PH_SP_HOLD1;
          arm_wait();
        end
      end
      PH_SP_HOLD1: begin
        if (wait_elapsed()) begin
          sda_drive_q = 1'b0;
          phase_q     = PH_SP_HOLD2;
          arm_wait();
        end
      end
      PH_SP_HOLD2: begin
        if (wait_elapsed()) begin
          phase_q = PH_IDLE;
          done    = 1'b1;
        end
      end
      default: phase_q = PH_IDLE;
    endcase
    rep.scl_low   = scl_drive_q;
    rep.sda_low   = sda_drive_q;
    rep.busy_res  = (phase_q != PH_IDLE);
    rep.done_res  = done;
    rep.read_byte = read_q;
    rep.nack      = nack_q;
    return rep;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bus_report_t want;
    bus_report_t got;
    if (!rst_ni) begin
      reset_master();
      expected_reports.delete();
      fail_count    = 0;
      expected_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = bus_report_t'(m_axis_tdata[$bits(bus_report_t)-1:0]);
        if (expected_reports.size() == 0) begin
          $error("result item with no expectation waiting: %h", got);
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          check_field("scl_low", want.scl_low, got.scl_low);
          check_field("sda_low", want.sda_low, got.sda_low);
          check_field("busy_res", want.busy_res, got.busy_res);
          check_field("done_res", want.done_res, got.done_res);
          check_field("read_byte", want.read_byte, got.read_byte);
          check_field("nack", want.nack, got.nack);
        end
      end
      if (cfg_we_i) half_ticks = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) expected_reports.push_back(advance_tick(s_axis_tdata));
      expected_left = expected_reports.size();
    end
  end

endmodule

>>> tb/i2c_byte_master_test.sv
// Top of the I2C byte master testbench: clock, reset, stimulus and verdict.
module i2c_byte_master_test;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cbm_pkg::*;

  localparam int unsigned RandomItems = 1100;
  localparam int unsigned QuietLimit  = 4000;
  localparam int unsigned ItemLimit   = 20000;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we        = 1'b0;
  logic [HalfW-1:0]    cfg_wdata     = '0;
  logic                s_axis_tvalid = 1'b0;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tready = 1'b0;
  logic                s_axis_tready;
  logic                m_axis_tvalid;
  logic [OutDataW-1:0] m_axis_tdata;

  int   fail_count;
  int   expected_left;
  int   sent_items   = 0;
  int   result_items = 0;
  int   done_count   = 0;
  logic bus_busy     = 1'b0;
  int   idle_mode    = 0;
  int   quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  i2c_byte_master dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  i2c_byte_master_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .fail_count   (fail_count),
    .expected_left(expected_left)
  );

  function automatic logic roll(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int unsigned sender_gap_pct();
    case (idle_mode)
      1:       return 54;
      3:       return 24;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned receiver_stall_pct();
    case (idle_mode)
      2:       return 54;
      3:       return 24;
      default: return 0;
    endcase
  endfunction

  always @(posedge clk_i) begin
    m_axis_tready <= rst_ni && !roll(receiver_stall_pct());
  end

  // Ends the run when neither channel moves an item for too long, or when the
  // master never settles and the item count runs far past a normal run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QuietLimit || sent_items > ItemLimit) begin
        $display("i2c_byte_master test failed");
        $finish;
      end
    end
  end

  // Every wait for a clock edge goes through here so that the result side is
  // tracked from values sampled at that edge.
  task automatic next_edge();
    @(posedge clk_i);
    if (m_axis_tvalid && m_axis_tready) begin
      result_items++;
      bus_busy = m_axis_tdata[2];
      if (m_axis_tdata[3]) done_count++;
    end
  endtask

  task automatic send_tick(logic offer, cmd_e cmd, logic [7:0] data, logic ack,
                           logic scl, logic sda);
    while (roll(sender_gap_pct())) begin
      s_axis_tvalid <= 1'b0;
      next_edge();
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, sda, scl, ack, data, cmd, offer};
    do next_edge(); while (!s_axis_tready);
    sent_items++;
  endtask

  // Random pin levels; SCL mostly reads high, low ticks act as stretching.
  task automatic noise_tick(int unsigned offer_pct);
    send_tick(roll(offer_pct), cmd_e'($urandom_range(0, 3)), 8'($urandom),
              1'($urandom_range(0, 1)), roll(85), 1'($urandom_range(0, 1)));
  endtask

  task automatic pause_until_drained();
    s_axis_tvalid <= 1'b0;
    do next_edge(); while (result_items != sent_items);
  endtask

  // Ticks the bus in bursts until the last result shows the master idle.
  task automatic settle_idle(int unsigned offer_pct);
    int burst;
    pause_until_drained();
    while (bus_busy) begin
      burst = $urandom_range(1, 40);
      repeat (burst) noise_tick(offer_pct);
      pause_until_drained();
    end
  endtask

  task automatic write_half(logic [HalfW-1:0] value);
    settle_idle(0);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    next_edge();
    cfg_we    <= 1'b0;
  endtask

  task automatic run_command(cmd_e cmd, logic [7:0] data, logic ack, int unsigned offer_pct);
    settle_idle(0);
    send_tick(1'b1, cmd, data, ack, roll(85), 1'($urandom_range(0, 1)));
    settle_idle(offer_pct);
  endtask

  initial begin
    int target;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    next_edge();

    // Directed: a stop at the reset half period, then each command at the
    // shortest half periods, zero included.
    run_command(CMD_STOP, 8'h00, 1'b0, 0);
    write_half(16'd1);
    run_command(CMD_START, 8'h00, 1'b0, 0);
    run_command(CMD_WRITE, 8'hFF, 1'b1, 0);
    run_command(CMD_READ, 8'h5A, 1'b1, 0);
    run_command(CMD_READ, 8'hA5, 1'b0, 0);
    run_command(CMD_STOP, 8'hFF, 1'b1, 0);
    write_half(16'd0);
    run_command(CMD_START, 8'hA5, 1'b1, 0);
    // A command is offered on every tick, so some land while busy and one on
    // the tick that completes the read.
    settle_idle(0);
    send_tick(1'b1, CMD_READ, 8'h00, 1'b1, 1'b1, 1'b0);
    repeat (60) send_tick(1'b1, CMD_WRITE, 8'h3C, 1'b0, 1'b1, 1'b1);
    settle_idle(0);

    // A longer half period; a stop needs only two waits.
    write_half(16'd40);
    run_command(CMD_STOP, 8'h00, 1'b0, 6);

    for (int m = 0; m < 4; m++) begin
      idle_mode = m;
      for (int k = 0; k < 4; k++) begin
        write_half((k == 3) ? 16'($urandom_range(4, 12)) : 16'($urandom_range(0, 3)));
        target = sent_items + RandomItems / 16;
        while (sent_items < target) begin
          run_command(cmd_e'($urandom_range(0, 3)), 8'($urandom),
                      1'($urandom_range(0, 1)), 6);
        end
      end
    end

    idle_mode = 0;
    pause_until_drained();
    repeat (10) next_edge();
    if (expected_left != 0) $error("expectations left over: %0d", expected_left);
    $display("Run covered %0d items and %0d completed commands, half periods 0 to 40,",
             sent_items, done_count);
    $display("with idle-free, sender-idle, receiver-stall and mixed stretches.");
    if (fail_count == 0 && expected_left == 0) begin
      $display("i2c_byte_master test passed");
    end else begin
      $display("i2c_byte_master test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/i2cbm_pkg.sv
sv/i2c_byte_master.sv
tb/i2c_byte_master_checker.sv
tb/i2c_byte_master_test.sv
